/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mnf_pkg.sv */
// ----------------------------------------------------------------------------
// mnf_pkg
// constants, types, exp2 table and divider step for the note-to-frequency block
// ----------------------------------------------------------------------------
package mnf_pkg;

  // table shape
  localparam int EXP_TABLE_ENTRIES      = 64;
  localparam int MANTISSA_FRACTION_BITS = 16;

  // field widths
  localparam int NOTE_W  = 7;
  localparam int REF_W   = 24;
  localparam int STEPS_W = 8;
  localparam int FREQ_W  = 32;

  // fixed constants of the conversion
  localparam int NOTE_REF  = 69;
  localparam int NOTE_MAX  = 127;
  localparam int MIN_STEPS = 5;

  // configuration port
  localparam int CFG_DATA_W  = REF_W;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REFERENCE_FREQUENCY = 1'b0,
    CFG_STEPS_PER_OCTAVE    = 1'b1
  } cfg_reg_t;

  localparam logic [REF_W-1:0]   REF_RESET   = 24'd450560;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd12;

  // octave quotient range
  localparam int Q_MAG = (NOTE_REF + MIN_STEPS - 1) / MIN_STEPS;
  localparam int Q_MAX = (NOTE_MAX - NOTE_REF) / MIN_STEPS;
  localparam int A_MAX = (NOTE_REF > NOTE_MAX - NOTE_REF) ? NOTE_REF : NOTE_MAX - NOTE_REF;
  localparam int QB    = $clog2(A_MAX / MIN_STEPS + 1);
  localparam int QW    = $clog2((Q_MAG > Q_MAX + 1) ? Q_MAG : Q_MAX + 1) + 1;

  // mantissa and table widths
  localparam int TW  = MANTISSA_FRACTION_BITS + 2;
  localparam int KW  = $clog2(EXP_TABLE_ENTRIES);
  localparam int IW  = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int TDW = STEPS_W + KW;

  typedef logic [EXP_TABLE_ENTRIES:0][TW-1:0] exp_table_t;

  // truncated n-th power of c in q2.30, frozen once it passes 2.0
  function automatic logic [63:0] pow_q30(input logic [63:0] c, input int n);
    logic [63:0] p;
    logic        done;
    p    = 64'd1 << 30;
    done = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!done) begin
        p = (p * c) >> 30;
        if (p > (64'd1 << 31)) done = 1'b1;
      end
    end
    return p;
  endfunction

  function automatic exp_table_t build_exp_table();
    exp_table_t  tab;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] c;
    logic [63:0] p;
    int          sh;
    lo = 64'd1 << 30;
    hi = 64'd1 << 31;
    sh = 30 - MANTISSA_FRACTION_BITS;
    for (int k = 0; k < 31; k++) begin
      mid = (lo + hi) >> 1;
      if (pow_q30(mid, EXP_TABLE_ENTRIES) <= (64'd1 << 31)) lo = mid;
      else hi = mid;
    end
    c = lo;
    p = 64'd1 << 30;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      tab[i] = TW'((p + (64'd1 << (sh - 1))) >> sh);
      p      = (p * c) >> 30;
    end
    tab[EXP_TABLE_ENTRIES] = TW'(64'd2 << MANTISSA_FRACTION_BITS);
    return tab;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

  function automatic int max_step(input exp_table_t tab);
    int m;
    m = 0;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      if (int'(tab[i+1] - tab[i]) > m) m = int'(tab[i+1] - tab[i]);
    end
    return m;
  endfunction

  localparam int DW  = $clog2(max_step(EXP_TABLE) + 1);
  localparam int PDW = DW + STEPS_W;

  // scaling widths
  localparam int PW      = REF_W + TW;
  localparam int LSH_MAX = (Q_MAX > TW) ? Q_MAX - TW : 0;
  localparam int XW      = PW + LSH_MAX;
  localparam int SHW     = $clog2(TW + Q_MAG + 1) + 1;

  typedef struct packed {
    logic                      valid;
    logic signed [QW-1:0]      q;
    logic        [STEPS_W-1:0] r;
  } qr_t;

  typedef struct packed {
    logic                 valid;
    logic signed [QW-1:0] q;
    logic        [TW-1:0] m;
  } mant_t;

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] frequency;
    logic              saturated;
  } result_t;

  // one restoring division step: {remainder, quotient bit}
  function automatic logic [STEPS_W:0] div_step(input logic [STEPS_W-1:0] rem,
                                                input logic din,
                                                input logic [STEPS_W-1:0] divisor);
    logic [STEPS_W:0] cand;
    logic [STEPS_W:0] res;
    cand = {rem, din};
    if (cand >= {1'b0, divisor}) begin
      res = {STEPS_W'(cand - {1'b0, divisor}), 1'b1};
    end else begin
      res = {cand[STEPS_W-1:0], 1'b0};
    end
    return res;
  endfunction

endpackage

/* hdl/mnf_if.sv */
// ----------------------------------------------------------------------------
// mnf channels
// valid/ready channels for notes in and frequencies out
// ----------------------------------------------------------------------------
interface mnf_note_if;
  logic                        valid;
  logic                        ready;
  logic [mnf_pkg::NOTE_W-1:0]  note_number;

  modport source (output valid, output note_number, input ready);
  modport sink (input valid, input note_number, output ready);
endinterface

interface mnf_result_if;
  logic                        valid;
  logic                        ready;
  logic [mnf_pkg::FREQ_W-1:0]  frequency;
  logic                        saturated;

  modport source (output valid, output frequency, output saturated, input ready);
  modport sink (input valid, input frequency, input saturated, output ready);
endinterface

/* hdl/midi_note_to_frequency.sv */
// ----------------------------------------------------------------------------
// midi_note_to_frequency
// equal-tempered note frequency with configurable octave split and reference
// ----------------------------------------------------------------------------
//
//   channel   dir  payload                          accepted when
//   notes     in   note_number[6:0]                 notes.valid & notes.ready
//   results   out  frequency[31:0], saturated       results.valid & results.ready
//   cfg       in   cfg_index[0], cfg_data[23:0]     cfg_we
//
// one item per cycle unless the pipeline holds; a note reaches results through
// thirty registers: the three restoring dividers (4, 6 and 11 quotient bits,
// one bit a stage) and nine others, the output buffer included
// rst is synchronous and clears every valid bit, the output buffer and the
// two configuration registers (440 Hz, 12 steps)
// a two-entry output buffer lets notes flow while one result waits; the whole
// pipeline holds only when the buffer is full and results stalls
//
module midi_note_to_frequency (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mnf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mnf_pkg::CFG_DATA_W-1:0]   cfg_data,
  mnf_note_if.sink                         notes,
  mnf_result_if.source                     results
);

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_ONE   = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  // configuration registers; steps are held already clamped to the minimum
  logic [mnf_pkg::REF_W-1:0]   reference_frequency;
  logic [mnf_pkg::STEPS_W-1:0] steps_per_octave;

  // pipeline links
  mnf_pkg::qr_t     qr;
  mnf_pkg::mant_t   mant;
  mnf_pkg::result_t res;
  logic             pipe_adv;

  // output buffer: head is what results shows, tail is the skid entry
  logic [1:0]                 fill;
  logic [1:0]                 fill_next;
  logic                       push;
  logic                       pop;
  logic [mnf_pkg::FREQ_W-1:0] hd_freq;
  logic                       hd_sat;
  logic [mnf_pkg::FREQ_W-1:0] tl_freq;
  logic                       tl_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_frequency <= mnf_pkg::REF_RESET;
      steps_per_octave    <= mnf_pkg::STEPS_RESET;
    end else if (cfg_we) begin
      unique case (mnf_pkg::cfg_reg_t'(cfg_index))
        mnf_pkg::CFG_REFERENCE_FREQUENCY: begin
          reference_frequency <= cfg_data[mnf_pkg::REF_W-1:0];
        end
        mnf_pkg::CFG_STEPS_PER_OCTAVE: begin
          // fewer than five steps behaves as five
          steps_per_octave <=
            (cfg_data[mnf_pkg::STEPS_W-1:0] < mnf_pkg::STEPS_W'(mnf_pkg::MIN_STEPS))
              ? mnf_pkg::STEPS_W'(mnf_pkg::MIN_STEPS)
              : cfg_data[mnf_pkg::STEPS_W-1:0];
        end
      endcase
    end
  end

  // every stage moves together unless a finished result has nowhere to go
  assign pipe_adv    = !(res.valid && (fill == FILL_FULL) && !results.ready);
  assign notes.ready = pipe_adv;

  // octave quotient and step remainder
  mnf_floor_div u_floor_div (
    .clk         (clk),
    .rst         (rst),
    .adv         (pipe_adv),
    .in_valid    (notes.valid),
    .note_number (notes.note_number),
    .steps       (steps_per_octave),
    .qr          (qr)
  );

  // fractional power of two from the table
  mnf_mantissa u_mantissa (
    .clk   (clk),
    .rst   (rst),
    .adv   (pipe_adv),
    .qr    (qr),
    .steps (steps_per_octave),
    .mant  (mant)
  );

  // scale by the reference and the octave
  mnf_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .adv       (pipe_adv),
    .mant      (mant),
    .reference (reference_frequency),
    .res       (res)
  );

  // output buffer bookkeeping
  always_comb begin
    push      = res.valid && pipe_adv;
    pop       = (fill != FILL_EMPTY) && results.ready;
    fill_next = 2'(fill + 2'(push) - 2'(pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= FILL_EMPTY;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    // head takes a new item when it is free or being emptied with nothing behind
    if (push && ((fill == FILL_EMPTY) || ((fill == FILL_ONE) && pop))) begin
      hd_freq <= res.frequency;
      hd_sat  <= res.saturated;
    end else if (pop && (fill == FILL_FULL)) begin
      hd_freq <= tl_freq;
      hd_sat  <= tl_sat;
    end
    // tail fills when the head stays occupied
    if (push && (((fill == FILL_ONE) && !pop) || (fill == FILL_FULL))) begin
      tl_freq <= res.frequency;
      tl_sat  <= res.saturated;
    end
  end

  assign results.valid     = fill != FILL_EMPTY;
  assign results.frequency = hd_freq;
  assign results.saturated = hd_sat;

endmodule

/* hdl/mnf_floor_div.sv */
// ----------------------------------------------------------------------------
// mnf_floor_div
// floor quotient and remainder of note - 69 by the step count, one bit a stage
// ----------------------------------------------------------------------------
module mnf_floor_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [mnf_pkg::NOTE_W-1:0]   note_number,
  input  logic [mnf_pkg::STEPS_W-1:0]  steps,
  output mnf_pkg::qr_t                 qr
);

  localparam int QB = mnf_pkg::QB;
  localparam int QW = mnf_pkg::QW;
  localparam int NW = mnf_pkg::NOTE_W;
  localparam int SW = mnf_pkg::STEPS_W;

  logic [QB:0]   v;
  logic          neg [0:QB];
  logic [SW-1:0] rem [0:QB];
  logic [QB-1:0] w   [0:QB];

  logic          neg_in;
  logic [NW-1:0] mag_in;

  logic                 out_v;
  logic signed [QW-1:0] out_q;
  logic        [SW-1:0] out_r;

  logic                 nz;
  logic        [QW-1:0] qmag;
  logic signed [QW-1:0] q_next;
  logic        [SW-1:0] r_next;

  // sign and magnitude of the offset from the reference note
  always_comb begin
    neg_in = note_number < NW'(mnf_pkg::NOTE_REF);
    mag_in = neg_in ? NW'(mnf_pkg::NOTE_REF) - note_number
                    : note_number - NW'(mnf_pkg::NOTE_REF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg[0] <= neg_in;
      rem[0] <= SW'(mag_in >> QB);
      w[0]   <= mag_in[QB-1:0];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [SW:0] step;
    assign step = mnf_pkg::div_step(rem[j], w[j][QB-1], steps);

    always_ff @(posedge clk) begin
      if (adv) begin
        neg[j+1] <= neg[j];
        rem[j+1] <= step[SW:1];
        w[j+1]   <= QB'({w[j], step[0]});
      end
    end
  end

  // turn the truncated magnitude quotient into a floor quotient
  always_comb begin
    nz     = rem[QB] != '0;
    qmag   = QW'(w[QB]) + QW'(nz);
    q_next = neg[QB] ? -$signed(qmag) : $signed(QW'(w[QB]));
    r_next = (neg[QB] && nz) ? steps - rem[QB] : rem[QB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= v[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= q_next;
      out_r <= r_next;
    end
  end

  always_comb begin
    qr.valid = out_v;
    qr.q     = out_q;
    qr.r     = out_r;
  end

endmodule

/* hdl/mnf_mantissa.sv */
// ----------------------------------------------------------------------------
// mnf_mantissa
// 2^(r/steps) in q1.f by exp2 table lookup and linear interpolation
// ----------------------------------------------------------------------------
module mnf_mantissa (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  mnf_pkg::qr_t                 qr,
  input  logic [mnf_pkg::STEPS_W-1:0]  steps,
  output mnf_pkg::mant_t               mant
);

  localparam int KW  = mnf_pkg::KW;
  localparam int DW  = mnf_pkg::DW;
  localparam int TW  = mnf_pkg::TW;
  localparam int IW  = mnf_pkg::IW;
  localparam int QW  = mnf_pkg::QW;
  localparam int SW  = mnf_pkg::STEPS_W;
  localparam int TDW = mnf_pkg::TDW;
  localparam int PDW = mnf_pkg::PDW;
  localparam int L   = KW + DW + 4;

  logic [L-1:0] vld;

  // table index division stages
  logic signed [QW-1:0] aq   [0:KW];
  logic        [SW-1:0] arem [0:KW];
  logic        [KW-1:0] aw   [0:KW];

  // lookup stage
  logic signed [QW-1:0] lk_q;
  logic        [TW-1:0] lk_tk;
  logic        [DW-1:0] lk_diff;
  logic        [SW-1:0] lk_e;

  // interpolation division stages
  logic signed [QW-1:0] bq   [0:DW];
  logic        [TW-1:0] btk  [0:DW];
  logic        [SW-1:0] brem [0:DW];
  logic        [DW-1:0] bw   [0:DW];

  logic signed [QW-1:0] out_q;
  logic        [TW-1:0] out_m;

  logic [TDW-1:0] t_in;
  logic [IW-1:0]  idx0;
  logic [IW-1:0]  idx1;
  logic [PDW-1:0] prod_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], qr.valid};
    end
  end

  // t = r * entries
  assign t_in = TDW'(int'(qr.r) * mnf_pkg::EXP_TABLE_ENTRIES);

  always_ff @(posedge clk) begin
    if (adv) begin
      aq[0]   <= qr.q;
      arem[0] <= SW'(t_in >> KW);
      aw[0]   <= t_in[KW-1:0];
    end
  end

  for (genvar j = 0; j < KW; j++) begin : g_kstep
    logic [SW:0] step;
    assign step = mnf_pkg::div_step(arem[j], aw[j][KW-1], steps);

    always_ff @(posedge clk) begin
      if (adv) begin
        aq[j+1]   <= aq[j];
        arem[j+1] <= step[SW:1];
        aw[j+1]   <= KW'({aw[j], step[0]});
      end
    end
  end

  // neighbouring table entries
  always_comb begin
    idx0 = IW'(aw[KW]);
    idx1 = idx0 + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lk_q    <= aq[KW];
      lk_tk   <= mnf_pkg::EXP_TABLE[idx0];
      lk_diff <= DW'(mnf_pkg::EXP_TABLE[idx1] - mnf_pkg::EXP_TABLE[idx0]);
      lk_e    <= arem[KW];
    end
  end

  assign prod_e = PDW'(lk_diff) * PDW'(lk_e);

  always_ff @(posedge clk) begin
    if (adv) begin
      bq[0]   <= lk_q;
      btk[0]  <= lk_tk;
      brem[0] <= SW'(prod_e >> DW);
      bw[0]   <= prod_e[DW-1:0];
    end
  end

  for (genvar j = 0; j < DW; j++) begin : g_fstep
    logic [SW:0] step;
    assign step = mnf_pkg::div_step(brem[j], bw[j][DW-1], steps);

    always_ff @(posedge clk) begin
      if (adv) begin
        bq[j+1]   <= bq[j];
        btk[j+1]  <= btk[j];
        brem[j+1] <= step[SW:1];
        bw[j+1]   <= DW'({bw[j], step[0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q <= bq[DW];
      out_m <= btk[DW] + TW'(bw[DW]);
    end
  end

  always_comb begin
    mant.valid = vld[L-1];
    mant.q     = out_q;
    mant.m     = out_m;
  end

endmodule

/* hdl/mnf_scale.sv */
// ----------------------------------------------------------------------------
// mnf_scale
// reference times mantissa, shifted by the octave, truncated and saturated
// ----------------------------------------------------------------------------
module mnf_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  mnf_pkg::mant_t              mant,
  input  logic [mnf_pkg::REF_W-1:0]   reference,
  output mnf_pkg::result_t            res
);

  localparam int PW  = mnf_pkg::PW;
  localparam int XW  = mnf_pkg::XW;
  localparam int QW  = mnf_pkg::QW;
  localparam int SHW = mnf_pkg::SHW;
  localparam int FW  = mnf_pkg::FREQ_W;

  logic                 pv;
  logic signed [QW-1:0] pq;
  logic        [PW-1:0] prod;
  logic        [PW-1:0] prod_c;

  logic                  shamt_neg;
  logic signed [SHW-1:0] shamt;
  logic        [SHW-1:0] rsh;
  logic        [SHW-1:0] lsh;
  logic        [XW-1:0]  pext;
  logic        [XW-1:0]  wide;
  logic                  sat;

  logic          ov;
  logic [FW-1:0] ofreq;
  logic          osat;

  assign prod_c = reference * mant.m;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= mant.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pq   <= mant.q;
      prod <= prod_c;
    end
  end

  // product carries 10 + f fraction bits, result wants 8
  always_comb begin
    shamt     = SHW'(pq) - SHW'(mnf_pkg::MANTISSA_FRACTION_BITS + 2);
    shamt_neg = shamt[SHW-1];
    rsh       = -shamt;
    lsh       = shamt;
    pext      = XW'(prod);
    wide      = shamt_neg ? (pext >> rsh) : (pext << lsh);
    sat       = |wide[XW-1:FW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (adv) begin
      ov <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ofreq <= sat ? '1 : wide[FW-1:0];
      osat  <= sat;
    end
  end

  always_comb begin
    res.valid     = ov;
    res.frequency = ofreq;
    res.saturated = osat;
  end

endmodule

/* hdl/mnf_checker.sv */
// ----------------------------------------------------------------------------
// mnf_checker
// port-level checks on the note-to-frequency block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mnf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        note_ready,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [mnf_pkg::FREQ_W-1:0]  frequency,
  input logic                        saturated
);

  // with nothing waiting at the output the block must take notes
  `ASSERT_IMPLIES(a_empty_takes_notes, clk, rst, !result_valid, note_ready, "notes held while output empty")

  // a saturated result reads all ones
  `ASSERT_IMPLIES(a_sat_all_ones, clk, rst, result_valid && saturated, frequency == '1, "saturated result not all ones")

  // an offered item stays offered until taken
  `ASSERT_NEXT(a_valid_holds, clk, rst, result_valid && !result_ready, result_valid, "result withdrawn while stalled")

  // and its payload does not move
  `ASSERT_NEXT(a_payload_holds, clk, rst, result_valid && !result_ready, $stable(frequency) && $stable(saturated), "result changed while stalled")

endmodule

bind midi_note_to_frequency mnf_checker u_mnf_checker (
  .clk          (clk),
  .rst          (rst),
  .note_ready   (notes.ready),
  .result_valid (results.valid),
  .result_ready (results.ready),
  .frequency    (results.frequency),
  .saturated    (results.saturated)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for midi_note_to_frequency: random notes under several
// reference and octave-split settings, checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mnf_pkg::*;

  // quiet cycles allowed before the run is abandoned
  localparam int QUIET_LIMIT = 3000;
  // cycles left after the last result, about the pipeline latency
  localparam int TAIL_CYCLES = 40;
  // long receiver hold-off, starts after this many results
  localparam int HOLD_AFTER   = 100;
  localparam int HOLD_CYCLES  = 400;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned Q30_TWO = 64'd1 << 31;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              saturated;
  } freq_result_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  cfg_reg_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mnf_note_if   note_ch ();
  mnf_result_if result_ch ();

  midi_note_to_frequency dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .notes     (note_ch),
    .results   (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the configuration, changed only while the block is idle
  logic [REF_W-1:0]   ref_freq_cfg;
  logic [STEPS_W-1:0] steps_cfg;

  // exp2 lookup in q2.16, entry i close to 2^(i/entries)
  longint unsigned exp2_lut [0:EXP_TABLE_ENTRIES];

  logic [NOTE_W-1:0] note_queue [$];
  freq_result_t      expected_results [$];

  int  error_count = 0;
  int  results_seen = 0;
  int  note_gap = 0;
  int  result_hold = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b0;
  bit  hold_done = 1'b0;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // truncated n-th power in q2.30, bails out once past 2.0
  function automatic longint unsigned q30_power(input longint unsigned base, input int n);
    longint unsigned p;
    p = Q30_ONE;
    for (int i = 0; i < n; i++) begin
      p = (p * base) >> 30;
      if (p > Q30_TWO) return p;
    end
    return p;
  endfunction

  function automatic void build_exp2_lut();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned root;
    longint unsigned p;
    int              sh;
    lo = Q30_ONE;
    hi = Q30_TWO;
    sh = 30 - MANTISSA_FRACTION_BITS;
    // bisect for the largest step whose entries-th power stays within 2.0
    for (int k = 0; k < 31; k++) begin
      mid = (lo + hi) >> 1;
      if (q30_power(mid, EXP_TABLE_ENTRIES) <= Q30_TWO) lo = mid;
      else hi = mid;
    end
    root = lo;
    p    = Q30_ONE;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      exp2_lut[i] = (p + (64'd1 << (sh - 1))) >> sh;
      p           = (p * root) >> 30;
    end
    // the top entry is pinned to exactly two
    exp2_lut[EXP_TABLE_ENTRIES] = 64'd2 << MANTISSA_FRACTION_BITS;
  endfunction

  function automatic freq_result_t predict_frequency(input logic [NOTE_W-1:0] note);
    freq_result_t    res;
    int              steps;
    int              offset;
    int              octave;
    int              rem;
    int              shift;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned frac;
    longint unsigned mant;
    longint unsigned prod;
    longint unsigned scaled;
    // a divisor below the minimum is raised to it
    steps  = (int'(steps_cfg) < MIN_STEPS) ? MIN_STEPS : int'(steps_cfg);
    offset = int'(note) - NOTE_REF;
    // floor division, remainder kept non-negative
    octave = offset / steps;
    rem    = offset - octave * steps;
    if (rem < 0) begin
      rem    = rem + steps;
      octave = octave - 1;
    end
    // linear interpolation between neighbouring lookup entries
    pos  = longint'(rem) * EXP_TABLE_ENTRIES;
    idx  = pos / steps;
    frac = pos % steps;
    mant = exp2_lut[idx] + ((exp2_lut[idx + 1] - exp2_lut[idx]) * frac) / steps;
    prod = longint'(ref_freq_cfg) * mant;
    // q14.10 times q1.16 gives 26 fraction bits, the result wants 8
    shift = octave - (MANTISSA_FRACTION_BITS + 2);
    if (shift >= 0) scaled = prod << shift;
    else scaled = prod >> (-shift);
    if (scaled > 64'hFFFF_FFFF) begin
      res.frequency = '1;
      res.saturated = 1'b1;
    end else begin
      res.frequency = scaled[FREQ_W-1:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  // gap lengths: none while idle_on is clear, else mostly none or short, now and then long
  function automatic int draw_gap(input int pct_none);
    int pick;
    pick = $urandom_range(0, 99);
    if (!idle_on || pick < pct_none) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // note driver: offers the head of note_queue, holds it until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      note_ch.valid <= 1'b0;
      note_gap = 0;
    end else begin
      if (note_ch.valid && note_ch.ready) begin
        // item taken: work out what it must produce
        expected_results.push_back(predict_frequency(note_ch.note_number));
        void'(note_queue.pop_front());
        note_gap = draw_gap(55);
      end
      if (note_ch.valid && !note_ch.ready) begin
        // keep offering the same item
      end else if (note_gap > 0) begin
        note_gap = note_gap - 1;
        note_ch.valid <= 1'b0;
      end else if (note_queue.size() > 0) begin
        note_ch.valid       <= 1'b1;
        note_ch.note_number <= note_queue[0];
      end else begin
        note_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: random back-pressure, one long hold-off, field checks
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    freq_result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      result_hold = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        results_seen = results_seen + 1;
        if (expected_results.size() == 0) begin
          error_count = error_count + 1;
          $display("%0t unexpected result: expected none, got frequency %h saturated %b",
                   $time, result_ch.frequency, result_ch.saturated);
        end else begin
          want = expected_results.pop_front();
          if (result_ch.frequency !== want.frequency) begin
            error_count = error_count + 1;
            $display("%0t frequency mismatch: expected %h, got %h",
                     $time, want.frequency, result_ch.frequency);
          end
          if (result_ch.saturated !== want.saturated) begin
            error_count = error_count + 1;
            $display("%0t saturated mismatch: expected %b, got %b",
                     $time, want.saturated, result_ch.saturated);
          end
        end
        // stall long enough for the pipeline and buffer to back up
        if (!hold_done && results_seen == HOLD_AFTER) begin
          hold_done   = 1'b1;
          result_hold = HOLD_CYCLES;
        end
      end
      if (result_hold == 0) result_hold = draw_gap(70);
      if (result_hold > 0) begin
        result_hold = result_hold - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((note_ch.valid && note_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t timeout: no item moved for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------

  task automatic push_random_notes(input int count);
    for (int i = 0; i < count; i++) note_queue.push_back(NOTE_W'($urandom_range(0, NOTE_MAX)));
  endtask

  // wait until every item is taken and every result back
  task automatic wait_drain();
    @(negedge clk);
    while (note_queue.size() != 0 || expected_results.size() != 0 || note_ch.valid)
      @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_REFERENCE_FREQUENCY) ref_freq_cfg = data[REF_W-1:0];
    else steps_cfg = data[STEPS_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_config(input logic [REF_W-1:0] ref_freq, input logic [STEPS_W-1:0] steps);
    write_reg(CFG_REFERENCE_FREQUENCY, CFG_DATA_W'(ref_freq));
    write_reg(CFG_STEPS_PER_OCTAVE, CFG_DATA_W'(steps));
  endtask

  function automatic logic [REF_W-1:0] random_reference();
    case ($urandom_range(0, 3))
      0: return REF_W'($urandom());
      1: return REF_W'($urandom_range(1, 1023));
      2: return REF_W'($urandom_range(20, 8000) << 10);
      default: return REF_W'($urandom_range(24'hFFF000, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [STEPS_W-1:0] random_steps();
    case ($urandom_range(0, 5))
      0, 1: return STEPS_W'($urandom_range(5, 24));
      2, 3: return STEPS_W'($urandom_range(5, 255));
      4: return STEPS_W'($urandom_range(0, 4));
      default: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd5;
    endcase
  endfunction

  initial begin
    build_exp2_lut();
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = CFG_REFERENCE_FREQUENCY;
    cfg_data            = '0;
    note_ch.valid       = 1'b0;
    note_ch.note_number = '0;
    result_ch.ready     = 1'b0;
    ref_freq_cfg        = REF_RESET;
    steps_cfg           = STEPS_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, 440 Hz and 12 steps; long phase so the hold-off backs it up
    idle_on = 1'b1;
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    note_queue.push_back(7'd69);
    note_queue.push_back(7'd68);
    note_queue.push_back(7'd70);
    note_queue.push_back(7'd57);
    note_queue.push_back(7'd81);
    note_queue.push_back(7'd85);
    note_queue.push_back(7'd42);
    push_random_notes(300);
    wait_drain();

    // zero reference gives zero everywhere, never saturated
    idle_on = 1'b0;
    set_config('0, 8'd12);
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    note_queue.push_back(7'd69);
    push_random_notes(30);
    wait_drain();

    // largest reference with the fewest steps: upper notes saturate
    idle_on = 1'b1;
    set_config('1, 8'd5);
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    note_queue.push_back(7'd100);
    push_random_notes(60);
    wait_drain();

    // largest reference with the most steps
    idle_on = 1'b0;
    set_config('1, 8'd255);
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    push_random_notes(40);
    wait_drain();

    // divisor of zero, raised to the minimum
    idle_on = 1'b1;
    set_config(random_reference(), 8'd0);
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    push_random_notes(40);
    wait_drain();

    // smallest nonzero reference, divisor just below the minimum
    set_config(24'd1, 8'd4);
    note_queue.push_back(7'd0);
    note_queue.push_back(7'd127);
    push_random_notes(40);
    wait_drain();

    // random settings, idling on in most of them
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3) != 1;
      set_config(random_reference(), random_steps());
      push_random_notes(40);
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
